FILE: hw/rtl/tbsat_pkg.sv
// tbsat_pkg: shared types and constants for the triangle / box overlap test
// no dependencies; imported by every pipeline stage and the top level

package tbsat_pkg;

  localparam int NUM_EDGES = 3;

  // per-stage control: word valid plus the x/y axis separation flag
  typedef struct packed {
    logic vld;
    logic sep;
  } stage_ctl_t;

endpackage

FILE: hw/rtl/tbsat_prep.sv
// tbsat_prep: stage 1, box-relative doubled vertices, edge normals, x/y axis test
// depends on tbsat_pkg

module tbsat_prep
  import tbsat_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] vx [NUM_EDGES],
  input  logic signed [COORD_BITS-1:0] vy [NUM_EDGES],
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic        [COORD_BITS-1:0] w,
  input  logic        [COORD_BITS-1:0] h,
  output stage_ctl_t                   ctl_o,
  output logic signed [COORD_BITS+1:0] tx_o [NUM_EDGES],
  output logic signed [COORD_BITS+1:0] ty_o [NUM_EDGES],
  output logic signed [COORD_BITS:0]   nx_o [NUM_EDGES],
  output logic signed [COORD_BITS:0]   ny_o [NUM_EDGES],
  output logic        [COORD_BITS:0]   anx_o [NUM_EDGES],
  output logic        [COORD_BITS:0]   any_o [NUM_EDGES],
  output logic        [COORD_BITS-1:0] w_o,
  output logic        [COORD_BITS-1:0] h_o
);

  localparam int TW = COORD_BITS + 2;
  localparam int NW = COORD_BITS + 1;

  stage_ctl_t           ctl_r, ctl_nxt;
  logic signed [TW-1:0] tx_r [NUM_EDGES], tx_nxt [NUM_EDGES];
  logic signed [TW-1:0] ty_r [NUM_EDGES], ty_nxt [NUM_EDGES];
  logic signed [NW-1:0] nx_r [NUM_EDGES], nx_nxt [NUM_EDGES];
  logic signed [NW-1:0] ny_r [NUM_EDGES], ny_nxt [NUM_EDGES];
  logic        [NW-1:0] anx_r [NUM_EDGES], anx_nxt [NUM_EDGES];
  logic        [NW-1:0] any_r [NUM_EDGES], any_nxt [NUM_EDGES];
  logic [COORD_BITS-1:0] w_r, h_r;
  logic signed [TW-1:0] wp, wn, hp, hn;
  logic [NUM_EDGES-1:0] xlo, xhi, ylo, yhi;

  always_comb begin
    wp = $signed({2'b00, w});
    hp = $signed({2'b00, h});
    wn = -wp;
    hn = -hp;
    for (int i = 0; i < NUM_EDGES; i++) begin
      tx_nxt[i] = ($signed({vx[i][COORD_BITS-1], vx[i]}) -
                   $signed({cx[COORD_BITS-1], cx})) <<< 1;
      ty_nxt[i] = ($signed({vy[i][COORD_BITS-1], vy[i]}) -
                   $signed({cy[COORD_BITS-1], cy})) <<< 1;
      nx_nxt[i] = $signed({vy[i][COORD_BITS-1], vy[i]}) -
                  $signed({vy[(i+1)%NUM_EDGES][COORD_BITS-1], vy[(i+1)%NUM_EDGES]});
      ny_nxt[i] = $signed({vx[(i+1)%NUM_EDGES][COORD_BITS-1], vx[(i+1)%NUM_EDGES]}) -
                  $signed({vx[i][COORD_BITS-1], vx[i]});
      anx_nxt[i] = nx_nxt[i][NW-1] ? NW'(-nx_nxt[i]) : NW'(nx_nxt[i]);
      any_nxt[i] = ny_nxt[i][NW-1] ? NW'(-ny_nxt[i]) : NW'(ny_nxt[i]);
      xlo[i] = tx_nxt[i] < wn;
      xhi[i] = tx_nxt[i] > wp;
      ylo[i] = ty_nxt[i] < hn;
      yhi[i] = ty_nxt[i] > hp;
    end
    ctl_nxt.vld = in_vld;
    ctl_nxt.sep = (&xlo) | (&xhi) | (&ylo) | (&yhi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r  <= tx_nxt;
      ty_r  <= ty_nxt;
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      anx_r <= anx_nxt;
      any_r <= any_nxt;
      w_r   <= w;
      h_r   <= h;
    end
  end

  assign ctl_o = ctl_r;
  assign tx_o  = tx_r;
  assign ty_o  = ty_r;
  assign nx_o  = nx_r;
  assign ny_o  = ny_r;
  assign anx_o = anx_r;
  assign any_o = any_r;
  assign w_o   = w_r;
  assign h_o   = h_r;

endmodule

FILE: hw/rtl/tbsat_mul.sv
// tbsat_mul: stage 2, projection products per edge normal and box extent products
// depends on tbsat_pkg

module tbsat_mul
  import tbsat_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  stage_ctl_t                     ctl_i,
  input  logic signed [COORD_BITS+1:0]   tx [NUM_EDGES],
  input  logic signed [COORD_BITS+1:0]   ty [NUM_EDGES],
  input  logic signed [COORD_BITS:0]     nx [NUM_EDGES],
  input  logic signed [COORD_BITS:0]     ny [NUM_EDGES],
  input  logic        [COORD_BITS:0]     anx [NUM_EDGES],
  input  logic        [COORD_BITS:0]     any [NUM_EDGES],
  input  logic        [COORD_BITS-1:0]   w,
  input  logic        [COORD_BITS-1:0]   h,
  output stage_ctl_t                     ctl_o,
  output logic signed [2*COORD_BITS+2:0] pax_o [NUM_EDGES],
  output logic signed [2*COORD_BITS+2:0] pay_o [NUM_EDGES],
  output logic signed [2*COORD_BITS+2:0] pcx_o [NUM_EDGES],
  output logic signed [2*COORD_BITS+2:0] pcy_o [NUM_EDGES],
  output logic        [2*COORD_BITS:0]   rw_o [NUM_EDGES],
  output logic        [2*COORD_BITS:0]   rh_o [NUM_EDGES]
);

  localparam int PRW = 2 * COORD_BITS + 3;
  localparam int UW  = 2 * COORD_BITS + 1;

  stage_ctl_t            ctl_r;
  logic signed [PRW-1:0] pax_r [NUM_EDGES], pax_nxt [NUM_EDGES];
  logic signed [PRW-1:0] pay_r [NUM_EDGES], pay_nxt [NUM_EDGES];
  logic signed [PRW-1:0] pcx_r [NUM_EDGES], pcx_nxt [NUM_EDGES];
  logic signed [PRW-1:0] pcy_r [NUM_EDGES], pcy_nxt [NUM_EDGES];
  logic        [UW-1:0]  rw_r [NUM_EDGES], rw_nxt [NUM_EDGES];
  logic        [UW-1:0]  rh_r [NUM_EDGES], rh_nxt [NUM_EDGES];

  // both end points of an edge project alike onto its normal
  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      pax_nxt[i] = tx[i] * nx[i];
      pay_nxt[i] = ty[i] * ny[i];
      pcx_nxt[i] = tx[(i+2)%NUM_EDGES] * nx[i];
      pcy_nxt[i] = ty[(i+2)%NUM_EDGES] * ny[i];
      rw_nxt[i]  = w * anx[i];
      rh_nxt[i]  = h * any[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pax_r <= pax_nxt;
      pay_r <= pay_nxt;
      pcx_r <= pcx_nxt;
      pcy_r <= pcy_nxt;
      rw_r  <= rw_nxt;
      rh_r  <= rh_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign pax_o = pax_r;
  assign pay_o = pay_r;
  assign pcx_o = pcx_r;
  assign pcy_o = pcy_r;
  assign rw_o  = rw_r;
  assign rh_o  = rh_r;

endmodule

FILE: hw/rtl/tbsat_sum.sv
// tbsat_sum: stage 3, triangle projections and box half-extent per edge normal
// depends on tbsat_pkg

module tbsat_sum
  import tbsat_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  stage_ctl_t                     ctl_i,
  input  logic signed [2*COORD_BITS+2:0] pax [NUM_EDGES],
  input  logic signed [2*COORD_BITS+2:0] pay [NUM_EDGES],
  input  logic signed [2*COORD_BITS+2:0] pcx [NUM_EDGES],
  input  logic signed [2*COORD_BITS+2:0] pcy [NUM_EDGES],
  input  logic        [2*COORD_BITS:0]   rw [NUM_EDGES],
  input  logic        [2*COORD_BITS:0]   rh [NUM_EDGES],
  output stage_ctl_t                     ctl_o,
  output logic signed [2*COORD_BITS+3:0] pa_o [NUM_EDGES],
  output logic signed [2*COORD_BITS+3:0] pc_o [NUM_EDGES],
  output logic        [2*COORD_BITS+1:0] r_o [NUM_EDGES]
);

  localparam int PRW = 2 * COORD_BITS + 3;
  localparam int PW  = 2 * COORD_BITS + 4;
  localparam int RW  = 2 * COORD_BITS + 2;

  stage_ctl_t           ctl_r;
  logic signed [PW-1:0] pa_r [NUM_EDGES], pa_nxt [NUM_EDGES];
  logic signed [PW-1:0] pc_r [NUM_EDGES], pc_nxt [NUM_EDGES];
  logic        [RW-1:0] r_r [NUM_EDGES], r_nxt [NUM_EDGES];

  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      pa_nxt[i] = $signed({pax[i][PRW-1], pax[i]}) + $signed({pay[i][PRW-1], pay[i]});
      pc_nxt[i] = $signed({pcx[i][PRW-1], pcx[i]}) + $signed({pcy[i][PRW-1], pcy[i]});
      r_nxt[i]  = {1'b0, rw[i]} + {1'b0, rh[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pa_nxt;
      pc_r <= pc_nxt;
      r_r  <= r_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign pa_o  = pa_r;
  assign pc_o  = pc_r;
  assign r_o   = r_r;

endmodule

FILE: hw/rtl/tbsat_cmp.sv
// tbsat_cmp: stage 4, edge normal interval compare and the output word register
// depends on tbsat_pkg

module tbsat_cmp
  import tbsat_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  stage_ctl_t                     ctl_i,
  input  logic signed [2*COORD_BITS+3:0] pa [NUM_EDGES],
  input  logic signed [2*COORD_BITS+3:0] pc [NUM_EDGES],
  input  logic        [2*COORD_BITS+1:0] r [NUM_EDGES],
  output logic                           out_valid,
  output logic                           out_overlap
);

  localparam int PW = 2 * COORD_BITS + 4;

  logic                 out_valid_r, overlap_r, overlap_nxt;
  logic signed [PW-1:0] rp, rn;
  logic [NUM_EDGES-1:0] sep;

  always_comb begin
    rp  = '0;
    rn  = '0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      rp = $signed({2'b00, r[i]});
      rn = -rp;
      sep[i] = ((pa[i] < rn) && (pc[i] < rn)) || ((pa[i] > rp) && (pc[i] > rp));
    end
    overlap_nxt = !(ctl_i.sep || (|sep));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = overlap_r;

endmodule

FILE: hw/rtl/triangle_box_separating_axis_test_top.sv
// triangle_box_separating_axis_test_top: 2D triangle versus box overlap, separating axis test
// depends on tbsat_pkg, tbsat_prep, tbsat_mul, tbsat_sum, tbsat_cmp
//
//   channel  handshake              word
//   in       in_valid / in_ready    triangle vertices, box center and size
//   out      out_valid / out_ready  overlap flag
//
// four register stages: prep, multiply, sum, compare into the output register
// one word per cycle unless out_ready stalls the output
// each stage moves when it is empty or the stage after it moves, so bubbles
// close up while out_ready is low and in_ready drops only when all stages hold
// synchronous active-low reset clears the control bits (valid and separation flags) only

module triangle_box_separating_axis_test_top
  import tbsat_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_tri_ax,
  input  logic signed [COORD_BITS-1:0] in_tri_ay,
  input  logic signed [COORD_BITS-1:0] in_tri_bx,
  input  logic signed [COORD_BITS-1:0] in_tri_by,
  input  logic signed [COORD_BITS-1:0] in_tri_cx,
  input  logic signed [COORD_BITS-1:0] in_tri_cy,
  input  logic signed [COORD_BITS-1:0] in_box_center_x,
  input  logic signed [COORD_BITS-1:0] in_box_center_y,
  input  logic        [COORD_BITS-1:0] in_box_width,
  input  logic        [COORD_BITS-1:0] in_box_height,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_overlap
);

  localparam int TW  = COORD_BITS + 2;
  localparam int NW  = COORD_BITS + 1;
  localparam int PRW = 2 * COORD_BITS + 3;
  localparam int UW  = 2 * COORD_BITS + 1;
  localparam int PW  = 2 * COORD_BITS + 4;
  localparam int RW  = 2 * COORD_BITS + 2;

  logic en1, en2, en3, en_o;
  stage_ctl_t c1, c2, c3;

  logic signed [COORD_BITS-1:0] vx [NUM_EDGES];
  logic signed [COORD_BITS-1:0] vy [NUM_EDGES];

  logic signed [TW-1:0] tx [NUM_EDGES];
  logic signed [TW-1:0] ty [NUM_EDGES];
  logic signed [NW-1:0] nx [NUM_EDGES];
  logic signed [NW-1:0] ny [NUM_EDGES];
  logic        [NW-1:0] anx [NUM_EDGES];
  logic        [NW-1:0] any [NUM_EDGES];
  logic [COORD_BITS-1:0] w1, h1;

  logic signed [PRW-1:0] pax [NUM_EDGES];
  logic signed [PRW-1:0] pay [NUM_EDGES];
  logic signed [PRW-1:0] pcx [NUM_EDGES];
  logic signed [PRW-1:0] pcy [NUM_EDGES];
  logic        [UW-1:0]  rw [NUM_EDGES];
  logic        [UW-1:0]  rh [NUM_EDGES];

  logic signed [PW-1:0] pa [NUM_EDGES];
  logic signed [PW-1:0] pc [NUM_EDGES];
  logic        [RW-1:0] r [NUM_EDGES];

  assign vx[0] = in_tri_ax;
  assign vy[0] = in_tri_ay;
  assign vx[1] = in_tri_bx;
  assign vy[1] = in_tri_by;
  assign vx[2] = in_tri_cx;
  assign vy[2] = in_tri_cy;

  assign en_o     = !out_valid || out_ready;
  assign en3      = !c3.vld || en_o;
  assign en2      = !c2.vld || en3;
  assign en1      = !c1.vld || en2;
  assign in_ready = en1;

  tbsat_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en1),
    .in_vld (in_valid),
    .vx     (vx),
    .vy     (vy),
    .cx     (in_box_center_x),
    .cy     (in_box_center_y),
    .w      (in_box_width),
    .h      (in_box_height),
    .ctl_o  (c1),
    .tx_o   (tx),
    .ty_o   (ty),
    .nx_o   (nx),
    .ny_o   (ny),
    .anx_o  (anx),
    .any_o  (any),
    .w_o    (w1),
    .h_o    (h1)
  );

  tbsat_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en2),
    .ctl_i (c1),
    .tx    (tx),
    .ty    (ty),
    .nx    (nx),
    .ny    (ny),
    .anx   (anx),
    .any   (any),
    .w     (w1),
    .h     (h1),
    .ctl_o (c2),
    .pax_o (pax),
    .pay_o (pay),
    .pcx_o (pcx),
    .pcy_o (pcy),
    .rw_o  (rw),
    .rh_o  (rh)
  );

  tbsat_sum #(.COORD_BITS(COORD_BITS)) u_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en3),
    .ctl_i (c2),
    .pax   (pax),
    .pay   (pay),
    .pcx   (pcx),
    .pcy   (pcy),
    .rw    (rw),
    .rh    (rh),
    .ctl_o (c3),
    .pa_o  (pa),
    .pc_o  (pc),
    .r_o   (r)
  );

  tbsat_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en_o),
    .ctl_i       (c3),
    .pa          (pa),
    .pc          (pc),
    .r           (r),
    .out_valid   (out_valid),
    .out_overlap (out_overlap)
  );

endmodule

FILE: hw/rtl/tbsat_checker.sv
// tbsat_checker: port-level assertions for the overlap test pipeline
// depends on triangle_box_separating_axis_test_top, attached by bind below

module tbsat_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_overlap
);

  // a held result word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_overlap))
    else $error("output word changed while stalled");

  // an empty output register never backs up the input
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  // a taken result frees the whole pipeline
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is taken");

  // a stall can only come from a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back pressure");

endmodule

bind triangle_box_separating_axis_test_top tbsat_checker u_tbsat_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_overlap (out_overlap)
);
